// ===== rtl/touch_report_tracker_assert.svh =====
// Assertion macros used by the touch report tracker top level.
`ifndef TOUCH_REPORT_TRACKER_ASSERT_SVH
`define TOUCH_REPORT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch report tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TRT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch report tracker: next-cycle check failed");

`endif

// ===== rtl/trt_pkg.sv =====
// Types and constants of the touch report tracker.
`default_nettype none

package trt_pkg;

   localparam int NUM_POINTS  = 5;
   localparam int LAST_STORED = 3;    // points 1..3 are kept for the result
   localparam int POINT_W     = 12;
   localparam int COORD_W     = 16;
   localparam int SCREEN_W    = 13;
   localparam int FLAG_W      = 8;
   localparam int CNT_W       = 4;
   localparam int LANE_IDX_W  = 3;
   localparam int FAIL_W      = 3;

   localparam int FLAG_PRESSED = 7;
   localparam int FLAG_CAUGHT  = 6;
   localparam int STATUS_READY = 7;

   localparam logic [FAIL_W-1:0] FAIL_NONE   = 3'd0;
   localparam logic [FAIL_W-1:0] FAIL_STATUS = 3'd1;
   localparam logic [FAIL_W-1:0] FAIL_CLEAR  = 3'd2;
   localparam logic [FAIL_W-1:0] FAIL_POINT0 = 3'd3;

   localparam logic [7:0] STATUS_HELD_ZERO = 8'h00;
   localparam logic [7:0] STATUS_HELD_ALL  = 8'hFF;
   localparam logic [CNT_W-1:0] CNT_CLEAR_LIMIT = 4'd6;

   localparam logic [FLAG_W-1:0] FLAGS_TOUCH   = 8'hC0;
   localparam logic [FLAG_W-1:0] FLAGS_RELEASE = 8'h7F;
   localparam logic [FLAG_W-1:0] FLAGS_IDLE    = 8'hE0;
   localparam logic [COORD_W-1:0] NO_TOUCH     = 16'hFFFF;

   localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd800;
   localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [POINT_W-1:0] x;
      logic [POINT_W-1:0] y;
   } point_type;

   // per-lane findings passed to the merge stage
   typedef struct packed {
      logic sel;     // point is flagged valid by the count
      logic wr;      // point is read and stored
      logic stop;    // a read failed at or below this lane
   } lane_type;

   typedef struct packed {
      logic [FLAG_W-1:0]                   flags;
      logic [COORD_W-1:0]                  first_x;
      logic [COORD_W-1:0]                  first_y;
      logic [LAST_STORED:1][POINT_W-1:0]   xs;
      logic [LAST_STORED:1][POINT_W-1:0]   ys;
   } track_state_type;

endpackage

`default_nettype wire

// ===== rtl/trt_lane.sv =====
// One point lane: decides whether its point is read, stored or hits a bus failure.
`default_nettype none

module trt_lane (
   input  wire logic [trt_pkg::LANE_IDX_W-1:0] lane_idx,
   input  wire logic [trt_pkg::CNT_W-1:0]      cnt,
   input  wire logic [trt_pkg::FAIL_W-1:0]     fail_stage,
   input  wire logic                           stop_in,
   output trt_pkg::lane_type                   lane_out
);
   import trt_pkg::*;

   logic                sel;
   logic                hit;
   logic                stop;
   logic [FAIL_W-1:0]   my_fail;

   assign my_fail = FAIL_POINT0 + FAIL_W'(lane_idx);
   assign sel     = cnt > {1'b0, lane_idx};
   assign hit     = (fail_stage == my_fail);
   assign stop    = stop_in | (sel & hit);

   assign lane_out.sel  = sel;
   assign lane_out.wr   = sel & ~stop;
   assign lane_out.stop = stop;

endmodule

`default_nettype wire

// ===== rtl/trt_merge.sv =====
// Merge stage: combines lane results and the poll status into the next tracker state.
`default_nettype none

module trt_merge (
   input  wire trt_pkg::track_state_type                     cur,
   input  wire logic [7:0]                                   status_byte,
   input  wire logic [trt_pkg::FAIL_W-1:0]                   fail_stage,
   input  wire trt_pkg::point_type [trt_pkg::NUM_POINTS-1:0] pts,
   input  wire trt_pkg::lane_type  [trt_pkg::NUM_POINTS-1:0] lanes,
   input  wire logic [trt_pkg::SCREEN_W-1:0]                 screen_width,
   input  wire logic [trt_pkg::SCREEN_W-1:0]                 screen_height,
   output trt_pkg::track_state_type                          nxt,
   output logic                                              touched,
   output logic                                              reset_request
);
   import trt_pkg::*;

   logic [CNT_W-1:0]  cnt;
   logic [FLAG_W-1:0] low_mask;
   logic              pressed;
   logic              on_screen;
   logic              any_stop;

   assign cnt      = status_byte[CNT_W-1:0];
   assign pressed  = cur.flags[FLAG_PRESSED];
   assign any_stop = lanes[NUM_POINTS-1].stop;
   assign on_screen = ({1'b0, pts[0].x} < screen_width) &&
                      ({1'b0, pts[0].y} < screen_height);

   always_comb begin
      for (int b = 0; b < FLAG_W; b++) begin
         low_mask[b] = (cnt > CNT_W'(b));
      end
   end

   always_comb begin
      nxt           = cur;
      touched       = 1'b0;
      reset_request = 1'b0;
      priority if (fail_stage == FAIL_STATUS) begin
         reset_request = 1'b1;
      end else if (pressed && status_byte == STATUS_HELD_ZERO) begin
         touched = 1'b1;
      end else if (pressed && status_byte == STATUS_HELD_ALL) begin
         nxt.flags = '0;
      end else if (status_byte[STATUS_READY] && cnt < CNT_CLEAR_LIMIT &&
                   fail_stage == FAIL_CLEAR) begin
         reset_request = 1'b1;
      end else if (cnt == '0) begin
         if (status_byte[STATUS_READY]) begin
            if (pressed) begin
               nxt.flags = cur.flags & FLAGS_RELEASE;
            end else begin
               nxt.first_x = NO_TOUCH;
               nxt.first_y = NO_TOUCH;
               nxt.flags   = cur.flags & FLAGS_IDLE;
            end
         end
      end else begin
         nxt.flags = low_mask | FLAGS_TOUCH;
         if (lanes[0].wr) begin
            nxt.first_x = COORD_W'(pts[0].x);
            nxt.first_y = COORD_W'(pts[0].y);
         end
         for (int i = 1; i <= LAST_STORED; i++) begin
            if (lanes[i].wr) begin
               nxt.xs[i] = pts[i].x;
               nxt.ys[i] = pts[i].y;
            end
         end
         if (any_stop) begin
            reset_request = 1'b1;   // keep what was read before the failing point
         end else begin
            touched = 1'b1;
            if (!on_screen) begin
               if (cnt > 4'd1) begin
                  nxt.first_x = COORD_W'(pts[1].x);
                  nxt.first_y = COORD_W'(pts[1].y);
               end else if (pressed) begin
                  // lone off-screen point: old point, old flags, then release
                  nxt.first_x = cur.first_x;
                  nxt.first_y = cur.first_y;
                  nxt.flags   = cur.flags & FLAGS_RELEASE;
               end else begin
                  nxt.first_x = NO_TOUCH;
                  nxt.first_y = NO_TOUCH;
                  nxt.flags   = cur.flags & FLAGS_IDLE;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/touch_report_tracker.sv =====
// Top level of the touch report tracker: lanes, merge stage, state and handshakes.
//
// Each req_ beat is one poll of a touch controller: status byte, bus failure
// code and five raw coordinate pairs. Each poll gives exactly one rsp_ beat
// with the touch flag, the flag byte, the soft reset request and the stored
// points after the poll.
// Five point lanes judge their point in parallel; the merge stage folds their
// findings into the next state, which is written at the accepting edge.
// The result is registered: it is on rsp_ in the cycle after its req_ beat is taken.
// Throughput: one poll per cycle while rsp_ready stays high; the result
// register is the only stage, so req_ready follows rsp_ready when a result
// is waiting.
// When the receiver stalls, the result holds and req_ready stays low until
// the beat is taken.
// csr_ writes set the screen width (index 0) and height (index 1); the user must
// make them only while the block is idle, which the block itself does not enforce.
// Reset (synchronous, active high) clears the flags and points, restores the
// screen size to 800 by 480 and empties the result register.
`default_nettype none

`include "touch_report_tracker_assert.svh"

module touch_report_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_status_byte,
   input  wire logic [trt_pkg::FAIL_W-1:0]     req_fail_stage,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_x0,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_y0,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_x1,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_y1,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_x2,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_y2,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_x3,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_y3,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_x4,
   input  wire logic [trt_pkg::POINT_W-1:0]    req_raw_y4,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_touched,
   output logic [trt_pkg::FLAG_W-1:0]          rsp_touch_flags_out,
   output logic                                rsp_reset_request,
   output logic [trt_pkg::COORD_W-1:0]         rsp_first_x,
   output logic [trt_pkg::COORD_W-1:0]         rsp_first_y,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point1_x,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point1_y,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point2_x,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point2_y,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point3_x,
   output logic [trt_pkg::POINT_W-1:0]         rsp_point3_y,
   input  wire logic                           csr_we,
   input  wire logic                           csr_index,
   input  wire logic [trt_pkg::SCREEN_W-1:0]   csr_wdata
);
   import trt_pkg::*;

   track_state_type                     state_ff, state_in;
   logic                                touched_ff, touched_in;
   logic                                rreq_ff, rreq_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SCREEN_W-1:0]                 width_ff, width_in;
   logic [SCREEN_W-1:0]                 height_ff, height_in;

   logic                                req_accept;
   point_type [NUM_POINTS-1:0]          pts;
   lane_type  [NUM_POINTS-1:0]          lanes;
   logic      [NUM_POINTS:0]            stop_chain;
   logic      [NUM_POINTS-1:0]          wr_mask;
   track_state_type                     merged;
   logic                                merged_touched;
   logic                                merged_rreq;

   assign req_ready  = ~reset & (~rsp_valid_ff | rsp_ready);
   assign req_accept = req_valid & req_ready;

   assign pts[0] = '{x: req_raw_x0, y: req_raw_y0};
   assign pts[1] = '{x: req_raw_x1, y: req_raw_y1};
   assign pts[2] = '{x: req_raw_x2, y: req_raw_y2};
   assign pts[3] = '{x: req_raw_x3, y: req_raw_y3};
   assign pts[4] = '{x: req_raw_x4, y: req_raw_y4};

   assign stop_chain[0] = 1'b0;

   for (genvar i = 0; i < NUM_POINTS; i++) begin : g_lane
      trt_lane u_lane (
         .lane_idx   (LANE_IDX_W'(i)),
         .cnt        (req_status_byte[CNT_W-1:0]),
         .fail_stage (req_fail_stage),
         .stop_in    (stop_chain[i]),
         .lane_out   (lanes[i])
      );
      assign stop_chain[i+1] = lanes[i].stop;
      assign wr_mask[i]      = lanes[i].wr;
   end

   trt_merge u_merge (
      .cur           (state_ff),
      .status_byte   (req_status_byte),
      .fail_stage    (req_fail_stage),
      .pts           (pts),
      .lanes         (lanes),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .nxt           (merged),
      .touched       (merged_touched),
      .reset_request (merged_rreq)
   );

   always_comb begin
      state_in     = state_ff;
      touched_in   = touched_ff;
      rreq_in      = rreq_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         state_in     = merged;
         touched_in   = merged_touched;
         rreq_in      = merged_rreq;
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      touched_ff <= touched_in;
      rreq_ff    <= rreq_in;
   end

   // state only moves on an accepted beat, so it doubles as the result payload
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_touched         = touched_ff;
   assign rsp_reset_request   = rreq_ff;
   assign rsp_touch_flags_out = state_ff.flags;
   assign rsp_first_x         = state_ff.first_x;
   assign rsp_first_y         = state_ff.first_y;
   assign rsp_point1_x        = state_ff.xs[1];
   assign rsp_point1_y        = state_ff.ys[1];
   assign rsp_point2_x        = state_ff.xs[2];
   assign rsp_point2_y        = state_ff.ys[2];
   assign rsp_point3_x        = state_ff.xs[3];
   assign rsp_point3_y        = state_ff.ys[3];

   `TRT_ASSERT_IMP(a_touch_xor_rreq, clock, reset, rsp_valid_ff,
                   !(touched_ff && rreq_ff))
   `TRT_ASSERT_NXT(a_status_fail_hold, clock, reset,
                   req_accept && (req_fail_stage == FAIL_STATUS),
                   state_ff == $past(state_ff))
   `TRT_ASSERT_IMP(a_no_touch_pair, clock, reset, state_ff.first_x == NO_TOUCH,
                   state_ff.first_y == NO_TOUCH)
   `TRT_ASSERT_IMP(a_wr_prefix, clock, reset, req_accept,
                   (wr_mask & (wr_mask + NUM_POINTS'(1))) == '0)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the touch report tracker: directed polls, then random polls.
`timescale 1ns / 1ps

module tb_top;
   import trt_pkg::*;

   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam int IDLE_LIMIT   = 2000;   // cycles with no beat before giving up
   localparam int PHASE_ITEMS  = 155;
   localparam int PHASES       = 8;
   localparam int SLOT_SAVE    = 4;
   localparam logic [7:0] NO_POINT_MASK  = 8'h8F;
   localparam logic [7:0] NO_POINT_VALUE = 8'h80;

   typedef struct packed {
      logic [7:0]                              status;
      logic [FAIL_W-1:0]                       fail;
      logic [NUM_POINTS-1:0][POINT_W-1:0]      x;
      logic [NUM_POINTS-1:0][POINT_W-1:0]      y;
   } touch_poll_type;

   typedef struct packed {
      logic                 touched;
      logic [FLAG_W-1:0]    flags;
      logic                 reset_req;
      logic [COORD_W-1:0]   first_x;
      logic [COORD_W-1:0]   first_y;
      logic [POINT_W-1:0]   p1_x;
      logic [POINT_W-1:0]   p1_y;
      logic [POINT_W-1:0]   p2_x;
      logic [POINT_W-1:0]   p2_y;
      logic [POINT_W-1:0]   p3_x;
      logic [POINT_W-1:0]   p3_y;
   } touch_report_type;

   typedef struct {
      touch_poll_type     poll;
      bit                 typed;
      touch_report_type   want;
   } poll_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   wire logic             req_ready;
   logic [7:0]            req_status_byte = '0;
   logic [FAIL_W-1:0]     req_fail_stage = FAIL_NONE;
   logic [POINT_W-1:0]    req_raw_x0 = '0, req_raw_y0 = '0, req_raw_x1 = '0, req_raw_y1 = '0;
   logic [POINT_W-1:0]    req_raw_x2 = '0, req_raw_y2 = '0, req_raw_x3 = '0, req_raw_y3 = '0;
   logic [POINT_W-1:0]    req_raw_x4 = '0, req_raw_y4 = '0;
   wire logic             rsp_valid;
   logic                  rsp_ready = 1'b0;
   wire logic             rsp_touched;
   wire logic [FLAG_W-1:0]  rsp_touch_flags_out;
   wire logic             rsp_reset_request;
   wire logic [COORD_W-1:0] rsp_first_x, rsp_first_y;
   wire logic [POINT_W-1:0] rsp_point1_x, rsp_point1_y, rsp_point2_x, rsp_point2_y;
   wire logic [POINT_W-1:0] rsp_point3_x, rsp_point3_y;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_WIDTH;
   logic [SCREEN_W-1:0]   csr_wdata = '0;

   // tracker image kept by the testbench
   logic [FLAG_W-1:0]     trk_flags = '0;
   logic [COORD_W-1:0]    trk_x [NUM_POINTS];
   logic [COORD_W-1:0]    trk_y [NUM_POINTS];
   logic [SCREEN_W-1:0]   scr_width = WIDTH_RESET;
   logic [SCREEN_W-1:0]   scr_height = HEIGHT_RESET;

   touch_report_type expected_reports [$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  long_hold = 1'b0;

   touch_report_tracker dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      foreach (trk_x[i]) begin
         trk_x[i] = '0;
         trk_y[i] = '0;
      end
   end

   function automatic touch_report_type tracker_snapshot(input logic touched, input logic req);
      touch_report_type r;
      r.touched   = touched;
      r.flags     = trk_flags;
      r.reset_req = req;
      r.first_x   = trk_x[0];
      r.first_y   = trk_y[0];
      r.p1_x      = trk_x[1][POINT_W-1:0];
      r.p1_y      = trk_y[1][POINT_W-1:0];
      r.p2_x      = trk_x[2][POINT_W-1:0];
      r.p2_y      = trk_y[2][POINT_W-1:0];
      r.p3_x      = trk_x[3][POINT_W-1:0];
      r.p3_y      = trk_y[3][POINT_W-1:0];
      return r;
   endfunction

   // no-point poll: release if pressed, else park point 0 at the no-touch mark
   function automatic void release_or_idle(input logic [7:0] stat);
      if ((stat & NO_POINT_MASK) == NO_POINT_VALUE) begin
         if (trk_flags[FLAG_PRESSED]) begin
            trk_flags = trk_flags & FLAGS_RELEASE;
         end else begin
            trk_x[0]  = NO_TOUCH;
            trk_y[0]  = NO_TOUCH;
            trk_flags = trk_flags & FLAGS_IDLE;
         end
      end
   endfunction

   function automatic touch_report_type track_poll(input touch_poll_type p);
      logic [7:0]        stat;
      logic [CNT_W-1:0]  cnt;
      logic [FLAG_W-1:0] old_flags;
      logic [FLAG_W-1:0] mask;
      int                i;
      stat = p.status;
      if (p.fail == FAIL_STATUS)
         return tracker_snapshot(1'b0, 1'b1);
      if (trk_flags[FLAG_PRESSED]) begin
         if (stat == STATUS_HELD_ZERO)
            return tracker_snapshot(1'b1, 1'b0);
         if (stat == STATUS_HELD_ALL) begin
            trk_flags = '0;
            return tracker_snapshot(1'b0, 1'b0);
         end
      end
      cnt = stat[CNT_W-1:0];
      if (stat[STATUS_READY] && cnt < CNT_CLEAR_LIMIT && p.fail == FAIL_CLEAR)
         return tracker_snapshot(1'b0, 1'b1);
      if (cnt == 0) begin
         release_or_idle(stat);
         return tracker_snapshot(1'b0, 1'b0);
      end
      mask      = (cnt >= 4'd8) ? 8'h00 : (8'hFF << cnt);
      old_flags = trk_flags;
      trk_flags = ~mask | FLAGS_TOUCH;
      trk_x[SLOT_SAVE] = trk_x[0];
      trk_y[SLOT_SAVE] = trk_y[0];
      for (i = 0; i < NUM_POINTS; i++) begin
         if (trk_flags[i]) begin
            // a failed read keeps whatever was stored before it
            if (p.fail == FAIL_POINT0 + i)
               return tracker_snapshot(1'b0, 1'b1);
            trk_x[i] = {4'h0, p.x[i]};
            trk_y[i] = {4'h0, p.y[i]};
         end
      end
      if (!(trk_x[0] < scr_width && trk_y[0] < scr_height)) begin
         if (cnt > 1) begin
            trk_x[0] = trk_x[1];
            trk_y[0] = trk_y[1];
         end else begin
            trk_x[0]  = trk_x[SLOT_SAVE];
            trk_y[0]  = trk_y[SLOT_SAVE];
            stat      = NO_POINT_VALUE;
            trk_flags = old_flags;
         end
      end
      release_or_idle(stat);
      return tracker_snapshot(1'b1, 1'b0);
   endfunction

   function automatic touch_report_type report(input logic t, input logic [7:0] f,
                                               input logic rq,
                                               input logic [15:0] fx, input logic [15:0] fy,
                                               input logic [11:0] pt);
      touch_report_type r;
      r = '{t, f, rq, fx, fy, pt, pt, pt, pt, pt, pt};
      return r;
   endfunction

   function automatic poll_case_type row(input logic [7:0] status, input logic [2:0] fail,
                                         input logic [11:0] x0, input logic [11:0] y0,
                                         input logic [11:0] xr, input logic [11:0] yr,
                                         input bit typed, input touch_report_type want);
      poll_case_type c;
      int i;
      c.poll.status = status;
      c.poll.fail   = fail;
      for (i = 0; i < NUM_POINTS; i++) begin
         c.poll.x[i] = (i == 0) ? x0 : xr;
         c.poll.y[i] = (i == 0) ? y0 : yr;
      end
      c.typed = typed;
      c.want  = want;
      return c;
   endfunction

   function automatic logic [11:0] coord_within(input logic [SCREEN_W-1:0] bound);
      if (bound == 0 || bound > 4096)
         return 12'($urandom);
      return 12'($urandom_range(0, bound - 1));
   endfunction

   function automatic touch_poll_type random_poll();
      touch_poll_type p;
      int kind;
      int i;
      kind = $urandom_range(0, 99);
      if (kind < 65)
         p.status = {1'b1, 3'b000, 4'($urandom_range(0, 5))};
      else if (kind < 70)
         p.status = STATUS_HELD_ZERO;
      else if (kind < 75)
         p.status = STATUS_HELD_ALL;
      else
         p.status = 8'($urandom);
      p.fail = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : FAIL_NONE;
      for (i = 0; i < NUM_POINTS; i++) begin
         p.x[i] = ($urandom_range(0, 5) == 0) ? 12'($urandom) : coord_within(scr_width);
         p.y[i] = ($urandom_range(0, 5) == 0) ? 12'($urandom) : coord_within(scr_height);
      end
      return p;
   endfunction

   task automatic send_poll(input touch_poll_type p, input bit typed,
                            input touch_report_type want);
      touch_report_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_status_byte = p.status;
      req_fail_stage  = p.fail;
      req_raw_x0 = p.x[0];  req_raw_y0 = p.y[0];
      req_raw_x1 = p.x[1];  req_raw_y1 = p.y[1];
      req_raw_x2 = p.x[2];  req_raw_y2 = p.y[2];
      req_raw_x3 = p.x[3];  req_raw_y3 = p.y[3];
      req_raw_x4 = p.x[4];  req_raw_y4 = p.y[4];
      req_valid  = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = track_poll(p);
      expected_reports.push_back(typed ? want : predicted);
      burst_left--;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_screen(input logic idx, input logic [SCREEN_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_WIDTH)
         scr_width = value;
      else
         scr_height = value;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      touch_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual flags %0h", $time,
                     rsp_touch_flags_out);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("touched", 16'(want.touched), 16'(rsp_touched));
            check_field("touch_flags_out", 16'(want.flags), 16'(rsp_touch_flags_out));
            check_field("reset_request", 16'(want.reset_req), 16'(rsp_reset_request));
            check_field("first_x", want.first_x, rsp_first_x);
            check_field("first_y", want.first_y, rsp_first_y);
            check_field("point1_x", 16'(want.p1_x), 16'(rsp_point1_x));
            check_field("point1_y", 16'(want.p1_y), 16'(rsp_point1_y));
            check_field("point2_x", 16'(want.p2_x), 16'(rsp_point2_x));
            check_field("point2_y", 16'(want.p2_y), 16'(rsp_point2_y));
            check_field("point3_x", 16'(want.p3_x), 16'(rsp_point3_x));
            check_field("point3_y", 16'(want.p3_y), 16'(rsp_point3_y));
         end
      end
   end

   // watchdog: any beat or register write counts as progress
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: stall pattern changes from span to span, one long hold-off
   initial begin
      int  mode;
      int  span;
      int  tick;
      bit  hold_taken;
      tick = 0;
      hold_taken = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 128);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (long_hold && !hold_taken) begin
               hold_taken = 1'b1;
               rsp_ready  = 1'b0;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
            end else begin
               unique case (mode)
                  0: rsp_ready = 1'b1;
                  1: rsp_ready = 1'($urandom_range(0, 1));
                  2: rsp_ready = (tick % 3 == 0);
                  default: rsp_ready = ($urandom_range(0, 9) != 0);
               endcase
            end
         end
      end
   end

   initial begin
      poll_case_type       directed_cases [$];
      logic [SCREEN_W-1:0] w;
      logic [SCREEN_W-1:0] h;
      int                  phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      //                         status  fail           x0   y0   xr   yr   typed
      directed_cases.push_back(row(8'h81, FAIL_STATUS, 5, 6, 7, 8, 1,
                                   report(0, 8'h00, 1, 0, 0, 0)));
      directed_cases.push_back(row(8'h80, FAIL_NONE, 0, 0, 0, 0, 1,
                                   report(0, 8'h00, 0, NO_TOUCH, NO_TOUCH, 0)));
      directed_cases.push_back(row(8'h81, FAIL_NONE, 100, 200, 300, 400, 1,
                                   report(1, 8'hC1, 0, 100, 200, 0)));
      directed_cases.push_back(row(8'h00, FAIL_NONE, 9, 9, 9, 9, 1,
                                   report(1, 8'hC1, 0, 100, 200, 0)));
      directed_cases.push_back(row(8'hFF, FAIL_NONE, 9, 9, 9, 9, 1,
                                   report(0, 8'h00, 0, 100, 200, 0)));
      directed_cases.push_back(row(8'h85, FAIL_NONE, 4095, 4095, 4095, 4095, 1,
                                   report(1, 8'hDF, 0, 4095, 4095, 4095)));
      directed_cases.push_back(row(8'h85, FAIL_NONE, 0, 0, 0, 0, 1,
                                   report(1, 8'hDF, 0, 0, 0, 0)));
      // single point off screen: saved point and old flags come back, then release
      directed_cases.push_back(row(8'h81, FAIL_NONE, 800, 0, 7, 9, 1,
                                   report(1, 8'h5F, 0, 0, 0, 0)));
      directed_cases.push_back(row(8'h80, FAIL_NONE, 1, 2, 3, 4, 1,
                                   report(0, 8'h40, 0, NO_TOUCH, NO_TOUCH, 0)));
      directed_cases.push_back(row(8'h83, FAIL_CLEAR, 10, 20, 30, 40, 0, '0));
      directed_cases.push_back(row(8'h03, FAIL_CLEAR, 11, 21, 31, 41, 0, '0));
      directed_cases.push_back(row(8'h85, FAIL_POINT0 + 3'd2, 12, 22, 32, 42, 0, '0));
      directed_cases.push_back(row(8'h82, FAIL_POINT0 + 3'd3, 13, 23, 33, 43, 0, '0));
      directed_cases.push_back(row(8'h8F, FAIL_POINT0 + 3'd4, 14, 24, 34, 44, 0, '0));
      directed_cases.push_back(row(8'h86, FAIL_NONE, 15, 25, 35, 45, 0, '0));
      directed_cases.push_back(row(8'h88, FAIL_NONE, 16, 26, 36, 46, 0, '0));
      directed_cases.push_back(row(8'h00, FAIL_NONE, 17, 27, 37, 47, 0, '0));
      directed_cases.push_back(row(8'hFF, FAIL_NONE, 18, 28, 38, 48, 0, '0));
      directed_cases.push_back(row(8'h00, FAIL_NONE, 19, 29, 39, 49, 0, '0));
      directed_cases.push_back(row(8'h7F, FAIL_NONE, 2730, 1365, 1365, 2730, 0, '0));
      directed_cases.push_back(row(8'h80, FAIL_NONE, 20, 30, 40, 50, 0, '0));
      directed_cases.push_back(row(8'h80, FAIL_NONE, 21, 31, 41, 51, 0, '0));
      directed_cases.push_back(row(8'h81, FAIL_NONE, 799, 479, 60, 70, 0, '0));
      directed_cases.push_back(row(8'h82, FAIL_NONE, 799, 480, 61, 71, 0, '0));
      directed_cases.push_back(row(8'h40, FAIL_POINT0, 22, 32, 42, 52, 0, '0));

      foreach (directed_cases[i])
         send_poll(directed_cases[i].poll, directed_cases[i].typed, directed_cases[i].want);

      for (phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         unique case (phase)
            0: begin w = 13'd640;  h = 13'd480;  end
            1: begin w = 13'd0;    h = 13'd4096; end
            2: begin w = 13'd4096; h = 13'd0;    end
            3: begin w = 13'd1;    h = 13'd1;    end
            4: begin w = 13'd8191; h = 13'd8191; end
            7: begin w = WIDTH_RESET; h = HEIGHT_RESET; end
            default: begin
               w = 13'($urandom_range(1, 4096));
               h = 13'($urandom_range(1, 4096));
            end
         endcase
         write_screen(CSR_WIDTH, w);
         write_screen(CSR_HEIGHT, h);
         if (phase == 5)
            long_hold = 1'b1;
         repeat (PHASE_ITEMS) send_poll(random_poll(), 1'b0, '0);
      end

      settle_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== touch_report_tracker.f =====
+incdir+rtl
rtl/trt_pkg.sv
rtl/trt_lane.sv
rtl/trt_merge.sv
rtl/touch_report_tracker.sv
verif/tb_top.sv
